### hdl/colour_tag_markup_parser_core_defines.svh
// Assertion macros shared by the parser's top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef COLOUR_TAG_MARKUP_PARSER_CORE_DEFINES_SVH
`define COLOUR_TAG_MARKUP_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTMP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ctmp_pkg.sv
package ctmp_pkg;

  // Hold buffer: an opening bracket plus up to eight following bytes.
  localparam int HOLD_DEPTH = 9;

  localparam logic [15:0] DEFAULT_COLOUR_RESET = 16'hFFFF;

  // Bytes with a meaning inside the markup.
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  glyph;
    logic [15:0] colour;
    logic        has_glyph;
    logic        last;
  } out_word_t;

  // Tag body: body[0] is the byte right after the opening bracket.
  typedef logic [6:0][7:0] body_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_SKIP,
    ST_FLUSH,
    ST_DRAIN
  } ctmp_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic parse_step;
    logic skip_step;
    logic flush_step;
    logic bare_mark;
    logic mark_last;
    logic end_string;
    logic push_out;
  } ctmp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pend_empty;
    logic held_empty;
    logic held_one;
    logic eot;
    logic emitted;
    logic res_valid;
    logic slot_free;
    logic step_emits;
    logic step_skip;
  } ctmp_status_t;

  // Named colours, text left-justified in 56 bits, first character on top.
  localparam logic [55:0] NAME_TXT [12] = '{
    {"red", 32'h0},   {"green", 16'h0},  {"blue", 24'h0},
    {"yellow", 8'h0}, {"cyan", 24'h0},   {"magenta"},
    {"white", 16'h0}, {"orange", 8'h0},  {"grey", 24'h0},
    {"gray", 24'h0},  {"skyblue"},       {"pink", 24'h0}
  };

  localparam logic [2:0] NAME_LEN [12] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd7, 3'd5, 3'd6, 3'd4, 3'd4, 3'd7, 3'd4
  };

  localparam logic [15:0] NAME_RGB [12] = '{
    16'hF800, 16'h07E0, 16'h001F, 16'hFFE0, 16'h07FF, 16'hF81F,
    16'hFFFF, 16'hFD20, 16'h8410, 16'h8410, 16'h867D, 16'hFE19
  };

  // Returns {valid, value} for one case-insensitive hex digit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return {1'b0, t[3:0]};
  endfunction

  // Matches a tag body of len bytes. Returns {hit, colour}.
  function automatic logic [16:0] tag_lookup(body_t body, logic [2:0] len,
                                             logic [15:0] dflt);
    logic        hit;
    logic [15:0] col;
    logic        ok;
    logic        hex_ok;
    logic [4:0]  d [6];
    logic [7:0]  rr;
    logic [7:0]  gg;
    logic [7:0]  bb;
    hit = 1'b0;
    col = 16'h0000;
    // Reset tag.
    if (len == 3'd1 && body[0] == CH_SLASH) begin
      hit = 1'b1;
      col = dflt;
    end
    // Hex colour, truncated to 565.
    hex_ok = 1'b1;
    for (int i = 0; i < 6; i++) begin
      d[i] = hex_digit(body[1 + i]);
      hex_ok &= d[i][4];
    end
    rr = {d[0][3:0], d[1][3:0]};
    gg = {d[2][3:0], d[3][3:0]};
    bb = {d[4][3:0], d[5][3:0]};
    if (len == 3'd7 && body[0] == CH_HASH && hex_ok) begin
      hit = 1'b1;
      col = {rr[7:3], gg[7:2], bb[7:3]};
    end
    // Palette names, case-sensitive.
    for (int n = 0; n < 12; n++) begin
      ok = (NAME_LEN[n] == len);
      for (int i = 0; i < 7; i++) begin
        if (3'(i) < NAME_LEN[n]) begin
          ok &= (body[i] == NAME_TXT[n][55 - 8 * i -: 8]);
        end
      end
      if (ok && !hit) begin
        hit = 1'b1;
        col = NAME_RGB[n];
      end
    end
    return {hit, col};
  endfunction

endpackage

### hdl/ctmp_dpath.sv
module ctmp_dpath
  import ctmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ctmp_cmd_t    cmd,
  output ctmp_status_t status,
  input  in_word_t     in_word,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  output logic         out_valid,
  input  logic         out_ready,
  output out_word_t    out_word
);

  // Held region is buf_r[0 .. hc_r-1], bytes waiting to be parsed follow it.
  logic [7:0]  buf_r   [HOLD_DEPTH];
  logic [7:0]  buf_nxt [HOLD_DEPTH];
  logic [3:0]  hc_r, hc_nxt;
  logic [3:0]  pc_r, pc_nxt;
  logic        eot_r, eot_nxt;
  logic        emitted_r, emitted_nxt;
  logic        at_start_r, at_start_nxt;
  logic [15:0] default_r, default_nxt;
  logic [15:0] cur_r, cur_nxt;
  out_word_t   res_r, res_nxt;
  logic        res_v_r, res_v_nxt;
  out_word_t   out_r, out_nxt;
  logic        out_v_r, out_v_nxt;

  logic [7:0]  cur_byte;
  logic [3:0]  n_held;
  logic        is_open;
  logic        is_close;
  body_t       body;
  logic [16:0] lookup;
  logic        tag_hit;
  logic        held_empty;
  logic        step_fail;
  logic        step_emits;
  logic        step_skip;
  logic        out_free;
  logic        slot_free;
  logic        do_shift;
  logic        emit_en;
  out_word_t   emit_word;

  // Next byte to parse and the tag body seen so far.
  always_comb begin
    cur_byte = 8'h00;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (hc_r == 4'(i)) begin
        cur_byte = buf_r[i];
      end
    end
    for (int i = 0; i < 7; i++) begin
      body[i] = buf_r[1 + i];
    end
  end

  // Decode of one parse step.
  assign n_held     = hc_r + 4'd1;
  assign is_open    = (cur_byte == CH_OPEN);
  assign is_close   = (cur_byte == CH_CLOSE);
  assign lookup     = tag_lookup(body, 3'(hc_r - 4'd1), default_r);
  assign tag_hit    = lookup[16];
  assign held_empty = (hc_r == 4'd0);
  assign step_fail  = !held_empty &&
                      ((is_close && !tag_hit) ||
                       (!is_close && n_held == 4'(HOLD_DEPTH)));
  assign step_emits = held_empty ? !is_open : step_fail;
  assign step_skip  = !held_empty && is_close && tag_hit && (pc_r != 4'd1);
  assign out_free   = !out_v_r || out_ready;
  assign slot_free  = !res_v_r || out_free;

  // Next-state logic of the datapath.
  always_comb begin
    buf_nxt      = buf_r;
    hc_nxt       = hc_r;
    pc_nxt       = pc_r;
    eot_nxt      = eot_r;
    emitted_nxt  = emitted_r;
    at_start_nxt = at_start_r;
    default_nxt  = default_r;
    cur_nxt      = cur_r;
    res_nxt      = res_r;
    res_v_nxt    = res_v_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r;
    do_shift     = 1'b0;
    emit_en      = 1'b0;
    emit_word    = '{glyph: buf_r[0], colour: cur_r, has_glyph: 1'b1, last: 1'b0};

    // A new word lands right after the held bytes.
    if (cmd.load) begin
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if (hc_r == 4'(i)) begin
          buf_nxt[i] = in_word.character;
        end
      end
      pc_nxt       = 4'd1;
      eot_nxt      = in_word.end_of_text;
      emitted_nxt  = 1'b0;
      at_start_nxt = 1'b0;
    end

    // One byte through the parser.
    if (cmd.parse_step) begin
      if (held_empty) begin
        pc_nxt = pc_r - 4'd1;
        if (is_open) begin
          hc_nxt = 4'd1;
        end else begin
          emit_en  = 1'b1;
          do_shift = 1'b1;
        end
      end else if (step_fail) begin
        // The bracket goes out as a literal, the rest is parsed again.
        emit_en  = 1'b1;
        do_shift = 1'b1;
        hc_nxt   = 4'd0;
        pc_nxt   = hc_r + pc_r - 4'd1;
      end else if (is_close) begin
        cur_nxt = lookup[15:0];
        pc_nxt  = pc_r - 4'd1;
        hc_nxt  = (pc_r == 4'd1) ? 4'd0 : n_held;
      end else begin
        hc_nxt = n_held;
        pc_nxt = pc_r - 4'd1;
      end
    end

    // Drop one byte of a matched tag ahead of the waiting bytes.
    if (cmd.skip_step) begin
      do_shift = 1'b1;
      hc_nxt   = hc_r - 4'd1;
    end

    // Flush one held byte at the end of the text.
    if (cmd.flush_step) begin
      emit_en  = 1'b1;
      do_shift = 1'b1;
      hc_nxt   = hc_r - 4'd1;
    end

    // Bare end marker when the string produced nothing.
    if (cmd.bare_mark) begin
      emit_en   = 1'b1;
      emit_word = '{glyph: 8'h00, colour: cur_r, has_glyph: 1'b0, last: 1'b1};
    end

    if (do_shift) begin
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
    end

    if (cmd.end_string) begin
      cur_nxt      = default_r;
      at_start_nxt = 1'b1;
    end

    // Register write; it reaches the current colour only between strings.
    if (cfg_we) begin
      default_nxt = cfg_wdata;
      if (at_start_r || cmd.end_string) begin
        cur_nxt = cfg_wdata;
      end
    end

    // Output handshake, then the staging register.
    if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
    if (emit_en) begin
      if (res_v_r) begin
        out_nxt   = res_r;
        out_v_nxt = 1'b1;
      end
      res_nxt     = emit_word;
      res_v_nxt   = 1'b1;
      emitted_nxt = 1'b1;
    end
    if (cmd.mark_last) begin
      res_nxt.last = 1'b1;
    end
    if (cmd.push_out) begin
      out_nxt   = res_r;
      out_v_nxt = 1'b1;
      res_v_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r       <= 4'd0;
      pc_r       <= 4'd0;
      eot_r      <= 1'b0;
      emitted_r  <= 1'b0;
      at_start_r <= 1'b1;
      default_r  <= DEFAULT_COLOUR_RESET;
      cur_r      <= DEFAULT_COLOUR_RESET;
      res_v_r    <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      hc_r       <= hc_nxt;
      pc_r       <= pc_nxt;
      eot_r      <= eot_nxt;
      emitted_r  <= emitted_nxt;
      at_start_r <= at_start_nxt;
      default_r  <= default_nxt;
      cur_r      <= cur_nxt;
      res_v_r    <= res_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  assign status = '{
    pend_empty: (pc_r == 4'd0),
    held_empty: held_empty,
    held_one:   (hc_r == 4'd1),
    eot:        eot_r,
    emitted:    emitted_r,
    res_valid:  res_v_r,
    slot_free:  slot_free,
    step_emits: step_emits,
    step_skip:  step_skip
  };

endmodule

### hdl/ctmp_ctrl.sv
module ctmp_ctrl
  import ctmp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  ctmp_status_t status,
  output ctmp_cmd_t    cmd
);

  ctmp_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (status.pend_empty) begin
          state_nxt = status.eot ? ST_FLUSH : ST_DRAIN;
        end else if (status.step_skip) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (status.held_one) begin
          state_nxt = ST_PARSE;
        end
      end
      ST_FLUSH: begin
        if (status.held_empty && (status.emitted || status.slot_free)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.res_valid || status.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Command decode.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_PARSE: begin
        // A step that emits waits for room in the staging register.
        if (!status.pend_empty) begin
          cmd.parse_step = !status.step_emits || status.slot_free;
        end
      end
      ST_SKIP: begin
        cmd.skip_step = 1'b1;
      end
      ST_FLUSH: begin
        if (!status.held_empty) begin
          cmd.flush_step = status.slot_free;
        end else if (status.emitted) begin
          cmd.mark_last  = 1'b1;
          cmd.end_string = 1'b1;
        end else if (status.slot_free) begin
          cmd.bare_mark  = 1'b1;
          cmd.end_string = 1'b1;
        end
      end
      ST_DRAIN: begin
        cmd.push_out = status.res_valid && status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/colour_tag_markup_parser_core.sv
// Channel  Direction  Handshake           Word
// in_      input      in_valid/in_ready   in_word (character, end_of_text)
// out_     output     out_valid/out_ready out_word (glyph, colour, has_glyph, last)
// cfg_     input      cfg_we              cfg_wdata (default colour)
//
// One word at a time: a new word is taken only once the previous one is fully parsed
// and staged out. Each byte parsed or replayed, each byte of a matched tag that is
// dropped ahead of later bytes and each byte flushed at the end of the text takes a
// step of its own, since the single shift-register hold buffer moves one byte per step.
// Synchronous active-low reset; no clearing pass is needed.
// A stalled result port holds the parser at its next emission.
`include "colour_tag_markup_parser_core_defines.svh"

module colour_tag_markup_parser_core
  import ctmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  ctmp_cmd_t    cmd;
  ctmp_status_t status;

  logic in_take;
  logic parser_clear;
  logic emit_req;
  logic last_req;

  // Sequencer.
  ctmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold buffer, tag matcher, colour state and result registers.
  ctmp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Conditions watched by the checks below.
  assign in_take      = in_valid && in_ready;
  assign parser_clear = status.pend_empty && !status.res_valid;
  assign emit_req     = (cmd.parse_step && status.step_emits) || cmd.flush_step ||
                        cmd.bare_mark;
  assign last_req     = cmd.mark_last || cmd.bare_mark;

  // A new word arrives only once the previous one is fully parsed and staged out.
  `CTMP_ASSERT_IMPL(a_accept_clean, in_take, parser_clear, "word accepted while parser busy")

  // Every emission has room in the staging register.
  `CTMP_ASSERT_IMPL(a_emit_room, emit_req, status.slot_free, "result emitted without room")

  // The final result of a string is still staged right after it is marked.
  `CTMP_ASSERT_NEXT(a_last_staged, last_req, status.res_valid, "last result lost")

endmodule
